FILE: src/dns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_pkg
// Types, codes and character classification shared by the directive name
// scanner blocks.
// ----------------------------------------------------------------------------
package dns_pkg;

    localparam int TEXT_BYTES_MAX = 16777216;
    localparam int NAME_CHARS_MAX = 127;
    localparam int POS_W          = 24;
    localparam int LEN_W          = $clog2(NAME_CHARS_MAX + 2);
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

    // keyword character index, one per character of #PRNAME
    localparam logic [2:0] KW_HASH = 3'd0;
    localparam logic [2:0] KW_P    = 3'd1;
    localparam logic [2:0] KW_R    = 3'd2;
    localparam logic [2:0] KW_N    = 3'd3;
    localparam logic [2:0] KW_A    = 3'd4;
    localparam logic [2:0] KW_M    = 3'd5;
    localparam logic [2:0] KW_E    = 3'd6;
    localparam logic [2:0] KW_NONE = 3'd7;
    localparam logic [2:0] KW_LEN  = 3'd7;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NO_ID   = 3'd1,
        ST_BAD_END = 3'd2,
        ST_DUP     = 3'd3,
        ST_LONG    = 3'd4,
        ST_MISSING = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        PH_NORMAL      = 4'd0,
        PH_LINE        = 4'd1,
        PH_BLOCK       = 4'd2,
        PH_STRING      = 4'd3,
        PH_KEYWORD     = 4'd4,
        PH_GAP         = 4'd5,
        PH_NAME        = 4'd6,
        PH_TRAIL       = 4'd7,
        PH_TRAIL_SLASH = 4'd8
    } t_phase;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  scan_status;
        logic [23:0] name_offset;
        logic [6:0]  name_length;
    } t_out_item;

    // classified byte handed from front to back
    typedef struct packed {
        logic             last;
        logic [POS_W-1:0] pos;
        logic [2:0]       kw_idx;
        logic             is_lead;
        logic             is_word;
        logic             is_sptab;
        logic             is_cr;
        logic             is_nl;
        logic             is_slash;
        logic             is_star;
        logic             is_quote;
        logic             is_bslash;
    } t_cls;

    function automatic logic [2:0] kw_index(input logic [7:0] c);
        logic [2:0] idx;
        case (c)
            8'h23:   idx = KW_HASH;
            8'h50:   idx = KW_P;
            8'h52:   idx = KW_R;
            8'h4E:   idx = KW_N;
            8'h41:   idx = KW_A;
            8'h4D:   idx = KW_M;
            8'h45:   idx = KW_E;
            default: idx = KW_NONE;
        endcase
        return idx;
    endfunction

endpackage

FILE: src/dns_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_front
// Accepts text bytes, classifies each one and tags it with its byte offset.
// ----------------------------------------------------------------------------
module dns_front
    import dns_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_data,
    input  logic     i_full,
    output logic     o_stall,
    output logic     o_push,
    output t_cls     o_cls
);

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(TEXT_BYTES_MAX - 1);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       c;

    assign c       = i_data.text_byte;
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cls.last      = i_data.end_of_text;
        o_cls.pos       = r_pos;
        o_cls.kw_idx    = kw_index(c);
        o_cls.is_lead   = (c inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F});
        o_cls.is_word   = (c inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F, [8'h30:8'h39]});
        o_cls.is_sptab  = (c inside {8'h20, 8'h09});
        o_cls.is_cr     = (c == 8'h0D);
        o_cls.is_nl     = (c == 8'h0A);
        o_cls.is_slash  = (c == 8'h2F);
        o_cls.is_star   = (c == 8'h2A);
        o_cls.is_quote  = (c == 8'h22);
        o_cls.is_bslash = (c == 8'h5C);
    end

    // offset restarts after the last byte of a text, saturates on long text
    always_comb begin
        n_pos = r_pos;
        if (o_push) begin
            if (i_data.end_of_text) begin
                n_pos = '0;
            end else if (r_pos != POS_LAST) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

FILE: src/dns_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_fifo
// Short queue of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module dns_fifo
    import dns_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cls o_data
);

    t_cls                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic [QUEUE_AW:0]   n_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

FILE: src/dns_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_back
// Scanner state machine: comments, strings, directive keyword and name,
// with a result register toward the output channel.
// ----------------------------------------------------------------------------
module dns_back
    import dns_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_cls      i_cls,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(NAME_CHARS_MAX);

    t_phase           r_phase,     n_phase;
    logic             r_als,       n_als;
    logic             r_esc,       n_esc;
    logic             r_slash_p,   n_slash_p;
    logic             r_star_p,    n_star_p;
    logic [2:0]       r_kw_pos,    n_kw_pos;
    logic             r_name_seen, n_name_seen;
    logic [POS_W-1:0] r_off,       n_off;
    logic [LEN_W-1:0] r_len,       n_len;
    logic             r_err_seen,  n_err_seen;
    logic             r_out_valid;
    t_out_item        r_out;

    t_status          e;
    logic             emit;
    logic             do_plain;
    logic             do_gap;
    logic             do_trail;
    t_out_item        res;

    // check done when a name line closes
    function automatic t_status name_check(input logic seen, input logic [LEN_W-1:0] len);
        t_status s;
        if (seen) begin
            s = ST_DUP;
        end else if (len > LEN_MAX) begin
            s = ST_LONG;
        end else begin
            s = ST_OK;
        end
        return s;
    endfunction

    assign o_pop       = i_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_phase     = r_phase;
        n_als       = r_als;
        n_esc       = r_esc;
        n_slash_p   = r_slash_p;
        n_star_p    = r_star_p;
        n_kw_pos    = r_kw_pos;
        n_name_seen = r_name_seen;
        n_off       = r_off;
        n_len       = r_len;
        n_err_seen  = r_err_seen;
        e           = ST_OK;
        emit        = 1'b0;
        do_plain    = 1'b0;
        do_gap      = 1'b0;
        do_trail    = 1'b0;

        if (o_pop && !r_err_seen) begin
            case (r_phase)
                PH_LINE: begin
                    if (i_cls.is_nl) begin
                        n_phase = PH_NORMAL;
                        n_als   = 1'b1;
                    end
                end
                PH_BLOCK: begin
                    if (r_star_p && i_cls.is_slash) begin
                        n_star_p = 1'b0;
                        n_phase  = PH_NORMAL;
                    end else begin
                        n_star_p = i_cls.is_star;
                        if (i_cls.is_nl) begin
                            n_als = 1'b1;
                        end
                    end
                end
                PH_STRING: begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                    end else if (i_cls.is_bslash) begin
                        n_esc = 1'b1;
                    end else if (i_cls.is_quote) begin
                        n_phase = PH_NORMAL;
                    end else if (i_cls.is_nl) begin
                        n_als = 1'b1;
                    end
                end
                PH_KEYWORD: begin
                    if (r_kw_pos < KW_LEN) begin
                        if (i_cls.kw_idx == r_kw_pos) begin
                            n_kw_pos = r_kw_pos + 1'b1;
                        end else begin
                            do_plain = 1'b1;
                        end
                    end else if (!i_cls.is_word) begin
                        n_phase  = PH_GAP;
                        n_kw_pos = '0;
                        do_gap   = 1'b1;
                    end else begin
                        do_plain = 1'b1;
                    end
                    if (do_plain) begin
                        n_kw_pos = '0;
                        n_als    = 1'b0;
                    end
                end
                PH_GAP: begin
                    do_gap = 1'b1;
                end
                PH_NAME: begin
                    if (i_cls.is_word) begin
                        if (r_len <= LEN_MAX) begin
                            n_len = r_len + 1'b1;
                        end
                    end else begin
                        n_phase  = PH_TRAIL;
                        do_trail = 1'b1;
                    end
                end
                PH_TRAIL: begin
                    do_trail = 1'b1;
                end
                PH_TRAIL_SLASH: begin
                    if (!i_cls.is_slash && !i_cls.is_star) begin
                        e = ST_BAD_END;
                    end else begin
                        e = name_check(r_name_seen, r_len);
                        if (e == ST_OK) begin
                            n_name_seen = 1'b1;
                            n_als       = 1'b0;
                            n_phase     = i_cls.is_slash ? PH_LINE : PH_BLOCK;
                            n_star_p    = 1'b0;
                        end
                    end
                end
                default: begin
                    do_plain = 1'b1;
                    if (r_slash_p) begin
                        n_slash_p = 1'b0;
                        if (i_cls.is_slash) begin
                            n_phase  = PH_LINE;
                            do_plain = 1'b0;
                        end else if (i_cls.is_star) begin
                            n_phase  = PH_BLOCK;
                            n_star_p = 1'b0;
                            do_plain = 1'b0;
                        end else begin
                            n_als = 1'b0;
                        end
                    end
                end
            endcase

            if (do_plain) begin
                n_phase = PH_NORMAL;
                if (i_cls.is_slash) begin
                    n_slash_p = 1'b1;
                end else if (i_cls.is_quote) begin
                    n_phase = PH_STRING;
                    n_esc   = 1'b0;
                    n_als   = 1'b0;
                end else if (i_cls.is_nl) begin
                    n_als = 1'b1;
                end else if (i_cls.is_sptab || i_cls.is_cr) begin
                    n_als = n_als;
                end else if (n_als && i_cls.kw_idx == KW_HASH) begin
                    n_phase  = PH_KEYWORD;
                    n_kw_pos = 3'd1;
                    n_als    = 1'b0;
                end else begin
                    n_als = 1'b0;
                end
            end

            if (do_gap) begin
                if (i_cls.is_sptab) begin
                    e = ST_OK;
                end else if (!i_cls.is_lead) begin
                    e = ST_NO_ID;
                end else begin
                    n_off   = i_cls.pos;
                    n_len   = LEN_W'(1);
                    n_phase = PH_NAME;
                end
            end

            if (do_trail) begin
                if (i_cls.is_sptab || i_cls.is_cr) begin
                    e = ST_OK;
                end else if (i_cls.is_slash) begin
                    n_phase = PH_TRAIL_SLASH;
                end else if (!i_cls.is_nl) begin
                    e = ST_BAD_END;
                end else begin
                    e = name_check(r_name_seen, r_len);
                    if (e == ST_OK) begin
                        n_name_seen = 1'b1;
                        n_phase     = PH_NORMAL;
                        n_als       = 1'b1;
                    end
                end
            end

            if (e != ST_OK) begin
                emit = 1'b1;
            end else if (i_cls.last) begin
                emit = 1'b1;
                // text closes: settle whatever directive is still open
                if (n_phase == PH_KEYWORD && n_kw_pos == KW_LEN) begin
                    e = ST_NO_ID;
                end else if (n_phase == PH_GAP) begin
                    e = ST_NO_ID;
                end else if (n_phase == PH_NAME || n_phase == PH_TRAIL) begin
                    e = name_check(n_name_seen, n_len);
                    if (e == ST_OK) begin
                        n_name_seen = 1'b1;
                    end
                end else if (n_phase == PH_TRAIL_SLASH) begin
                    e = ST_BAD_END;
                end
                if (e == ST_OK && !n_name_seen) begin
                    e = ST_MISSING;
                end
            end
            n_err_seen = (e != ST_OK);
        end

        // result fields taken before the end-of-text clear below
        res.scan_status = e;
        res.name_offset = (e == ST_OK) ? n_off : '0;
        res.name_length = (e == ST_OK) ? n_len[6:0] : '0;

        // every text starts from a clean state
        if (o_pop && i_cls.last) begin
            n_phase     = PH_NORMAL;
            n_als       = 1'b1;
            n_esc       = 1'b0;
            n_slash_p   = 1'b0;
            n_star_p    = 1'b0;
            n_kw_pos    = '0;
            n_name_seen = 1'b0;
            n_off       = '0;
            n_len       = '0;
            n_err_seen  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_NORMAL;
            r_als       <= 1'b1;
            r_esc       <= 1'b0;
            r_slash_p   <= 1'b0;
            r_star_p    <= 1'b0;
            r_kw_pos    <= '0;
            r_name_seen <= 1'b0;
            r_off       <= '0;
            r_len       <= '0;
            r_err_seen  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_als       <= n_als;
            r_esc       <= n_esc;
            r_slash_p   <= n_slash_p;
            r_star_p    <= n_star_p;
            r_kw_pos    <= n_kw_pos;
            r_name_seen <= n_name_seen;
            r_off       <= n_off;
            r_len       <= n_len;
            r_err_seen  <= n_err_seen;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= res;
        end
    end

endmodule

FILE: src/directive_name_scanner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// directive_name_scanner_top
// Scans source text for a #PRNAME directive and reports the name's offset
// and length, or the first error found.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  input   | in        | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//  output  | out       | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//
//  one byte per cycle sustained while the output is not stalled; the front
//  classifies each accepted byte into a 4-entry queue, and the back takes it
//  from the queue and updates its state into the result register
//  the queue lets the front keep taking bytes while a result waits
//  synchronous active-low reset clears scanner state, offset and queue
// ----------------------------------------------------------------------------
module directive_name_scanner_top
    import dns_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic push;
    logic pop;
    logic full;
    logic q_valid;
    t_cls front_cls;
    t_cls q_cls;

    dns_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_full  (full),
        .o_stall (o_in_stall),
        .o_push  (push),
        .o_cls   (front_cls)
    );

    dns_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cls),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_cls)
    );

    dns_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_cls       (q_cls),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
